FILE: hdl/deadline_event_timer_queue_unit_defines.svh
// ---------------------------------------------------------------------------
// deadline event timer queue: assertion macros
// concurrent checks on clk, empty bodies when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef DEADLINE_EVENT_TIMER_QUEUE_UNIT_DEFINES_SVH
`define DEADLINE_EVENT_TIMER_QUEUE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// check outside reset
`define DETQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also holds through reset
`define DETQ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DETQ_ASSERT(lbl, prop, msg)
`define DETQ_ASSERT_RST(lbl, prop, msg)
`endif

`endif

FILE: hdl/detq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// detq_pkg
// sizes, codes, transaction types and sequencer states of the timer queue
// ---------------------------------------------------------------------------
package detq_pkg;

  // table size and limits
  localparam int DEPTH       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // field widths
  localparam int OP_W     = 2;
  localparam int TIME_W   = 48;
  localparam int DELAY_W  = 32;
  localparam int TAG_W    = 32;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_QUEUE   = 2'd0;
  localparam logic [OP_W-1:0] OP_PROCESS = 2'd1;
  localparam logic [OP_W-1:0] OP_CANCEL  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL        = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_PENDING = 2'd2;

  // input transaction
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [TIME_W-1:0]  now;
    logic [DELAY_W-1:0] delay;
    logic [TAG_W-1:0]   work_tag;
    logic [SLOT_W-1:0]  slot;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic                fired;
    logic [TAG_W-1:0]    fired_tag;
    logic                arm;
    logic [TIME_W-1:0]   arm_delay;
    logic [SLOT_W-1:0]   assigned_slot;
    logic [STATUS_W-1:0] status;
    logic                last;
  } out_item_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_DECIDE
  } state_t;

endpackage

FILE: hdl/deadline_event_timer_queue_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// deadline_event_timer_queue_unit
// one-shot timer deadline queue over a slot table held in synchronous memory
// ---------------------------------------------------------------------------
// Usage:
// Input channel in_valid/in_stall/in_data carries one operation per
// transaction: queue an event, process expired events or cancel a slot,
// each with the current time. Result channel out_valid/out_stall/out_data
// returns one transaction for queue and cancel, and one per fired event
// for process (at least one); the final one of an operation has last set
// and carries the timer arm request.
// Every operation but a rejected cancel walks the deadline/tag memory, one
// slot a cycle through its single read port, to find the earliest pending
// deadline and the lowest free slot. Queue and cancel walk it once, and the
// next operation is taken only after the result. Process walks it once and
// then once more for every event it fires. A rejected cancel skips the walk
// and goes straight to its result.
// in_stall is high while an operation is in progress; the next operation is
// taken as soon as the last result sits in the output register.
// Reset clears the pending flags, the sequencer and the output register;
// the memory contents are not cleared and need no clearing pass.
// When the receiver stalls, the result holds in the output register and the
// sequencer waits before producing the next one.
// ---------------------------------------------------------------------------
`include "deadline_event_timer_queue_unit_defines.svh"

module deadline_event_timer_queue_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  detq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output detq_pkg::out_item_t out_data
);
  import detq_pkg::*;

  // sequencer
  state_t state_r, state_nxt;

  // latched operation
  logic [OP_W-1:0]   op_r;
  logic [TIME_W-1:0] now_r;
  logic [TIME_W-1:0] dl_new_r;
  logic [TAG_W-1:0]  tag_in_r;
  logic              cancel_bad_r;

  // slot table
  logic [DEPTH-1:0]  pending_r;
  logic [TIME_W-1:0] dl_mem  [DEPTH];
  logic [TAG_W-1:0]  tag_mem [DEPTH];

  // scan pipeline
  logic [IDX_W-1:0]  scan_addr_r;
  logic              rd_vld_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic [TIME_W-1:0] rd_dl_r;
  logic [TAG_W-1:0]  rd_tag_r;
  logic              best_vld_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [TIME_W-1:0] best_dl_r;
  logic [TAG_W-1:0]  best_tag_r;
  logic              free_vld_r;
  logic [IDX_W-1:0]  free_idx_r;

  // fired event waiting for its last flag
  logic              held_vld_r;
  logic [TAG_W-1:0]  held_tag_r;
  logic [CNT_W-1:0]  count_r;

  // output register
  logic              out_vld_r;
  out_item_t         out_data_r;

  // control
  logic              accept;
  logic              out_free;
  logic              scan_start;
  logic              scan_issue;
  logic              emit;
  out_item_t         emit_data;
  logic              mem_we;
  logic              pend_set;
  logic              pend_clr;
  logic [IDX_W-1:0]  pend_clr_idx;
  logic              fire;

  // datapath terms
  logic [TIME_W:0]   dl_sum;
  logic [TIME_W-1:0] dl_sat;
  logic              cslot_in_range;
  logic [IDX_W-1:0]  cslot_idx;
  logic              cancel_ok;
  logic              best_after_now;
  logic [TIME_W-1:0] rem_delay;
  logic              expired;
  logic              queue_arm;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign out_free = !out_vld_r || !out_stall;

  // new deadline, saturated at the top of the time range
  assign dl_sum = {1'b0, in_data.now} + (TIME_W + 1)'(in_data.delay);
  assign dl_sat = dl_sum[TIME_W] ? {TIME_W{1'b1}} : dl_sum[TIME_W-1:0];

  // cancel target check
  assign cslot_in_range = (9'(in_data.slot) < 9'(DEPTH));
  assign cslot_idx      = IDX_W'(in_data.slot);
  assign cancel_ok      = cslot_in_range && pending_r[cslot_idx];

  // arm terms from the scan result
  assign best_after_now = best_dl_r > now_r;
  assign rem_delay      = best_after_now ? (best_dl_r - now_r) : '0;
  assign expired        = best_vld_r && !best_after_now;
  assign queue_arm      = !best_vld_r || (best_dl_r > dl_new_r);

  // sequencer outputs
  always_comb begin
    scan_start   = 1'b0;
    scan_issue   = 1'b0;
    emit         = 1'b0;
    emit_data    = '0;
    mem_we       = 1'b0;
    pend_set     = 1'b0;
    pend_clr     = 1'b0;
    pend_clr_idx = best_idx_r;
    fire         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_data.op)
            OP_QUEUE, OP_PROCESS: begin
              scan_start = 1'b1;
            end
            OP_CANCEL: begin
              if (cancel_ok) begin
                pend_clr     = 1'b1;
                pend_clr_idx = cslot_idx;
                scan_start   = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        scan_issue = 1'b1;
      end
      ST_LAST: ;
      ST_DECIDE: begin
        case (op_r)
          OP_QUEUE: begin
            if (out_free) begin
              emit           = 1'b1;
              emit_data.last = 1'b1;
              if (free_vld_r) begin
                mem_we                  = 1'b1;
                pend_set                = 1'b1;
                emit_data.arm           = queue_arm;
                emit_data.arm_delay     = queue_arm ? (dl_new_r - now_r) : '0;
                emit_data.assigned_slot = SLOT_W'(free_idx_r);
                emit_data.status        = STATUS_OK;
              end else begin
                emit_data.status = STATUS_FULL;
              end
            end
          end
          OP_PROCESS: begin
            if (expired && (count_r < CNT_W'(MAX_RESULTS))) begin
              // flush the previous fired event, then take this one
              if (!held_vld_r || out_free) begin
                if (held_vld_r) begin
                  emit                = 1'b1;
                  emit_data.fired     = 1'b1;
                  emit_data.fired_tag = held_tag_r;
                end
                fire       = 1'b1;
                pend_clr   = 1'b1;
                scan_start = 1'b1;
              end
            end else if (out_free) begin
              // final result carries the arm request
              emit                = 1'b1;
              emit_data.fired     = held_vld_r;
              emit_data.fired_tag = held_vld_r ? held_tag_r : '0;
              emit_data.arm       = best_vld_r;
              emit_data.arm_delay = best_vld_r ? rem_delay : '0;
              emit_data.last      = 1'b1;
            end
          end
          OP_CANCEL: begin
            if (out_free) begin
              emit           = 1'b1;
              emit_data.last = 1'b1;
              if (cancel_bad_r) begin
                emit_data.status = STATUS_NOT_PENDING;
              end else begin
                emit_data.arm       = best_vld_r;
                emit_data.arm_delay = best_vld_r ? rem_delay : '0;
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_data.op)
            OP_QUEUE, OP_PROCESS: state_nxt = ST_SCAN;
            OP_CANCEL:            state_nxt = cancel_ok ? ST_SCAN : ST_DECIDE;
            default:              state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_addr_r == IDX_W'(DEPTH - 1)) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (scan_start) begin
          state_nxt = ST_SCAN;
        end else if (emit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // latch the operation on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r         <= in_data.op;
      now_r        <= in_data.now;
      dl_new_r     <= dl_sat;
      tag_in_r     <= in_data.work_tag;
      cancel_bad_r <= !cancel_ok;
    end
  end

  // deadline and tag memory, one write and one registered read port;
  // writes happen only after the scan has drained, so no forwarding is needed
  always_ff @(posedge clk) begin
    if (mem_we) begin
      dl_mem[free_idx_r]  <= dl_new_r;
      tag_mem[free_idx_r] <= tag_in_r;
    end
    rd_dl_r  <= dl_mem[scan_addr_r];
    rd_tag_r <= tag_mem[scan_addr_r];
  end

  // pending flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      if (pend_clr) begin
        pending_r[pend_clr_idx] <= 1'b0;
      end
      if (pend_set) begin
        pending_r[free_idx_r] <= 1'b1;
      end
    end
  end

  // scan address and read tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_addr_r <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      rd_vld_r <= scan_issue;
      if (scan_start) begin
        scan_addr_r <= '0;
      end else if (scan_issue) begin
        scan_addr_r <= scan_addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= scan_addr_r;
  end

  // earliest pending deadline and lowest free slot, one slot a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_vld_r <= 1'b0;
      free_vld_r <= 1'b0;
    end else if (scan_start) begin
      best_vld_r <= 1'b0;
      free_vld_r <= 1'b0;
    end else if (rd_vld_r) begin
      if (pending_r[rd_idx_r]) begin
        if (!best_vld_r || (rd_dl_r < best_dl_r)) begin
          best_vld_r <= 1'b1;
        end
      end else if (!free_vld_r) begin
        free_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      if (pending_r[rd_idx_r]) begin
        if (!best_vld_r || (rd_dl_r < best_dl_r)) begin
          best_idx_r <= rd_idx_r;
          best_dl_r  <= rd_dl_r;
          best_tag_r <= rd_tag_r;
        end
      end else if (!free_vld_r) begin
        free_idx_r <= rd_idx_r;
      end
    end
  end

  // fired event held back until the next scan decides its last flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_vld_r <= 1'b0;
      count_r    <= '0;
    end else if (accept) begin
      held_vld_r <= 1'b0;
      count_r    <= '0;
    end else if (fire) begin
      held_vld_r <= 1'b1;
      count_r    <= count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      held_tag_r <= best_tag_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (emit) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= emit_data;
    end
  end

  // checks
  `DETQ_ASSERT(a_write_free_slot, mem_we |-> !pending_r[free_idx_r], "write to a pending slot")
  `DETQ_ASSERT(a_fire_clears_one, fire |=> ($countones(pending_r) == $past($countones(pending_r)) - 1), "fire did not retire one event")
  `DETQ_ASSERT(a_fired_only_process, (emit && emit_data.fired) |-> (op_r == OP_PROCESS), "fired result outside process")
  `DETQ_ASSERT(a_scan_drained, (state_r == ST_DECIDE) |-> !rd_vld_r, "decision before scan drained")
  `DETQ_ASSERT_RST(a_reset_quiet, !rst_n |=> (!out_valid && !in_stall), "block not quiet after reset")

endmodule
